### src/smet_pkg.sv
// Shared types, codes and widths for the sparse matrix entry table.
package smet_pkg;

   localparam int CAPACITY_DEFAULT = 256;
   localparam int MAX_DIM_DEFAULT  = 1024;

   localparam int IDX_W    = 10;  // row and column index width
   localparam int VALUE_W  = 32;
   localparam int TOTAL_W  = 48;
   localparam int STATUS_W = 3;
   localparam int COUNT_W  = 9;   // width of the reported entry count
   localparam int CSR_W    = 11;  // width of each dimension register
   localparam int PADDR_W  = 3;
   localparam int PDATA_W  = 32;

   typedef enum logic [STATUS_W-1:0] {
      ST_UPDATED  = 3'd0,
      ST_INSERTED = 3'd1,
      ST_RANGE    = 3'd2,
      ST_FULL     = 3'd3,
      ST_SUM      = 3'd4
   } status_type;

   typedef enum logic {
      FUNC_WRITE = 1'b0,
      FUNC_QUERY = 1'b1
   } func_type;

   typedef enum logic {
      REG_ROWS = 1'b0,
      REG_COLS = 1'b1
   } reg_index_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_CHECK,
      S_SCAN,
      S_DRAIN,
      S_FINISH
   } state_type;

   typedef struct packed {
      logic accept;  // latch the input beat
      logic issue;   // read the next table entry
      logic finish;  // commit the item and load the result register
   } ctrl_cmd_type;

   typedef struct packed {
      logic skip_scan;   // range fault or empty table
      logic issue_last;  // current read address is the last stored entry
      logic out_free;    // result register can take a new beat
   } dp_status_type;

   typedef struct packed {
      logic [IDX_W-1:0]   row;
      logic [IDX_W-1:0]   col;
      logic [VALUE_W-1:0] value;
   } entry_type;

endpackage

### src/smet_ctrl.sv
// Sequencer for accept, table scan and commit of one item at a time.
module smet_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_ready,
   input  smet_pkg::dp_status_type stat,
   output smet_pkg::ctrl_cmd_type  cmd
);
   import smet_pkg::*;

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) state_in = S_CHECK;
         end
         S_CHECK: begin
            state_in = stat.skip_scan ? S_FINISH : S_SCAN;
         end
         S_SCAN: begin
            if (stat.issue_last) state_in = S_DRAIN;
         end
         S_DRAIN: begin
            state_in = S_FINISH;
         end
         S_FINISH: begin
            if (stat.out_free) state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_comb begin
      cmd       = '0;
      req_ready = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            req_ready  = 1'b1;
            cmd.accept = req_valid;
         end
         S_SCAN: begin
            cmd.issue = 1'b1;
         end
         S_FINISH: begin
            cmd.finish = stat.out_free;
         end
         default: ;
      endcase
   end

   // a scan never starts on an empty table or a faulty index
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_CHECK && stat.skip_scan) |=> state_ff == S_FINISH)
      else $error("scan started though it should be skipped");

   // the drain state follows the last read and leads straight to commit
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DRAIN) |=> (state_ff == S_FINISH && $past(cmd.issue, 2)))
      else $error("drain not preceded by the last read");

   assert property (@(posedge clock) disable iff (reset)
      cmd.finish |=> state_ff == S_IDLE)
      else $error("commit did not return to idle");

endmodule

### src/smet_datapath.sv
// Entry memory, fill count, scan compare, row accumulator and result register.
module smet_datapath #(
   parameter int CAPACITY = smet_pkg::CAPACITY_DEFAULT,
   parameter int MAX_DIM  = smet_pkg::MAX_DIM_DEFAULT
) (
   input  logic                           clock,
   input  logic                           reset,
   input  smet_pkg::ctrl_cmd_type         cmd,
   output smet_pkg::dp_status_type        stat,
   input  logic [smet_pkg::CSR_W-1:0]     rows_in_use,
   input  logic [smet_pkg::CSR_W-1:0]     cols_in_use,
   input  logic                           req_func,
   input  logic [smet_pkg::IDX_W-1:0]     req_row,
   input  logic [smet_pkg::IDX_W-1:0]     req_col,
   input  logic signed [smet_pkg::VALUE_W-1:0] req_value,
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output logic [smet_pkg::STATUS_W-1:0]  rsp_status,
   output logic signed [smet_pkg::TOTAL_W-1:0] rsp_row_total,
   output logic [smet_pkg::COUNT_W-1:0]   rsp_entry_count
);
   import smet_pkg::*;

   localparam int ADDR_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int CNT_W  = $clog2(CAPACITY + 1);
   localparam int DIM_W  = $clog2(MAX_DIM + 1);
   localparam int LIM_W  = (DIM_W > CSR_W) ? DIM_W : CSR_W;

   entry_type mem_ff [CAPACITY];

   logic [CNT_W-1:0]   count_ff, count_in;
   logic [ADDR_W-1:0]  rd_addr_ff;
   logic [ADDR_W-1:0]  rd_addr_q_ff;
   logic               rd_pend_ff;
   entry_type          rd_data_ff;

   func_type           func_ff;
   logic [IDX_W-1:0]   row_ff;
   logic [IDX_W-1:0]   col_ff;
   logic [VALUE_W-1:0] value_ff;
   logic               range_bad_ff, range_bad_in;

   logic                      hit_ff;
   logic [ADDR_W-1:0]         hit_addr_ff;
   logic signed [TOTAL_W-1:0] acc_ff;

   logic                      rsp_valid_ff;
   status_type                rsp_status_ff, rsp_status_in;
   logic signed [TOTAL_W-1:0] rsp_total_ff, rsp_total_in;
   logic [COUNT_W-1:0]        rsp_count_ff;

   logic [LIM_W-1:0] row_lim, col_lim;
   logic             do_write;
   logic [ADDR_W-1:0] wr_addr;

   // dimension limits, capped at MAX_DIM
   always_comb begin
      row_lim = (LIM_W'(rows_in_use) > LIM_W'(MAX_DIM)) ? LIM_W'(MAX_DIM)
                                                         : LIM_W'(rows_in_use);
      col_lim = (LIM_W'(cols_in_use) > LIM_W'(MAX_DIM)) ? LIM_W'(MAX_DIM)
                                                         : LIM_W'(cols_in_use);
      range_bad_in = (LIM_W'(req_row) >= row_lim) ||
                     ((req_func == FUNC_WRITE) && (LIM_W'(req_col) >= col_lim));
   end

   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         func_ff      <= func_type'(req_func);
         row_ff       <= req_row;
         col_ff       <= req_col;
         value_ff     <= req_value;
         range_bad_ff <= range_bad_in;
      end
   end

   // scan read port: address, then registered data in the next cycle
   always_ff @(posedge clock) begin
      if (reset) begin
         rd_pend_ff <= 1'b0;
      end else begin
         rd_pend_ff <= cmd.issue;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         rd_addr_ff <= '0;
      end else if (cmd.issue) begin
         rd_addr_ff <= rd_addr_ff + ADDR_W'(1);
      end
      if (cmd.issue) begin
         rd_data_ff   <= mem_ff[rd_addr_ff];
         rd_addr_q_ff <= rd_addr_ff;
      end
   end

   // compare stage
   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         hit_ff <= 1'b0;
         acc_ff <= '0;
      end else if (rd_pend_ff && rd_data_ff.row == row_ff) begin
         acc_ff <= acc_ff + TOTAL_W'($signed(rd_data_ff.value));
         if (rd_data_ff.col == col_ff) begin
            hit_ff      <= 1'b1;
            hit_addr_ff <= rd_addr_q_ff;
         end
      end
   end

   // commit decision
   always_comb begin
      do_write      = 1'b0;
      wr_addr       = hit_addr_ff;
      count_in      = count_ff;
      rsp_status_in = ST_RANGE;
      rsp_total_in  = '0;
      priority if (range_bad_ff) begin
         rsp_status_in = ST_RANGE;
      end else if (func_ff == FUNC_QUERY) begin
         rsp_status_in = ST_SUM;
         rsp_total_in  = acc_ff;
      end else if (hit_ff) begin
         rsp_status_in = ST_UPDATED;
         do_write      = 1'b1;
      end else if (count_ff >= CNT_W'(CAPACITY)) begin
         rsp_status_in = ST_FULL;
      end else begin
         rsp_status_in = ST_INSERTED;
         do_write      = 1'b1;
         wr_addr       = count_ff[ADDR_W-1:0];
         count_in      = count_ff + CNT_W'(1);
      end
   end

   // entries are never removed, so the occupied slots are exactly 0 .. count-1
   always_ff @(posedge clock) begin
      if (cmd.finish && do_write) begin
         mem_ff[wr_addr] <= '{row: row_ff, col: col_ff, value: value_ff};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (cmd.finish) begin
            count_ff     <= count_in;
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.finish) begin
         rsp_status_ff <= rsp_status_in;
         rsp_total_ff  <= rsp_total_in;
         rsp_count_ff  <= COUNT_W'(count_in);
      end
   end

   always_comb begin
      stat.skip_scan  = range_bad_ff || (count_ff == '0);
      stat.issue_last = (CNT_W'(rd_addr_ff) + CNT_W'(1)) == count_ff;
      stat.out_free   = !rsp_valid_ff || rsp_ready;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_row_total   = rsp_total_ff;
   assign rsp_entry_count = rsp_count_ff;

   assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(CAPACITY))
      else $error("fill count beyond capacity");

   // the count only moves on an insert beat
   assert property (@(posedge clock) disable iff (reset)
      (count_ff != $past(count_ff)) |->
         (rsp_valid_ff && rsp_status_ff == ST_INSERTED &&
          count_ff == $past(count_ff) + CNT_W'(1)))
      else $error("fill count moved without an insert");

   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_status_ff != ST_SUM) |-> rsp_total_ff == '0)
      else $error("non-zero total on a non-query result");

   // a result beat is only overwritten once it has been taken
   assert property (@(posedge clock) disable iff (reset)
      cmd.finish |-> (!rsp_valid_ff || rsp_ready))
      else $error("result overwritten while stalled");

endmodule

### src/sparse_matrix_entry_table.sv
// Top level: dimension registers on the APB port, sequencer and entry datapath.
//
//  channel   direction  handshake              payload
//  req       in         req_valid/req_ready    req_func req_row req_col req_value
//  rsp       out        rsp_valid/rsp_ready    rsp_status rsp_row_total rsp_entry_count
//  csr       in/out     psel/penable/pready    pwrite paddr pwdata prdata
//
// Each item is accepted, checked, scanned with one read of the entry memory per stored
// entry (at most CAPACITY), drained and committed; the result beat is registered at the
// commit. Range faults and an empty table skip the scan and the drain. Reset empties the
// table at once (fill count cleared) and restores both dimension registers to 1024.
// A stalled result holds the sequencer in commit; the next item is taken while an
// earlier result beat still waits.
module sparse_matrix_entry_table #(
   parameter int CAPACITY = smet_pkg::CAPACITY_DEFAULT,
   parameter int MAX_DIM  = smet_pkg::MAX_DIM_DEFAULT
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic                                req_func,
   input  logic [smet_pkg::IDX_W-1:0]          req_row,
   input  logic [smet_pkg::IDX_W-1:0]          req_col,
   input  logic signed [smet_pkg::VALUE_W-1:0] req_value,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic [smet_pkg::STATUS_W-1:0]       rsp_status,
   output logic signed [smet_pkg::TOTAL_W-1:0] rsp_row_total,
   output logic [smet_pkg::COUNT_W-1:0]        rsp_entry_count,
   input  logic                                psel,
   input  logic                                penable,
   input  logic                                pwrite,
   input  logic [smet_pkg::PADDR_W-1:0]        paddr,
   input  logic [smet_pkg::PDATA_W-1:0]        pwdata,
   output logic [smet_pkg::PDATA_W-1:0]        prdata,
   output logic                                pready
);
   import smet_pkg::*;

   localparam logic [CSR_W-1:0] DIM_RESET = CSR_W'(1024);

   logic [CSR_W-1:0] rows_ff;
   logic [CSR_W-1:0] cols_ff;
   reg_index_type    reg_sel;
   logic             wr_beat;
   ctrl_cmd_type     cmd;
   dp_status_type    stat;

   assign reg_sel = reg_index_type'(paddr[2]);
   assign wr_beat = psel && penable && pwrite;
   assign pready  = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         rows_ff <= DIM_RESET;
         cols_ff <= DIM_RESET;
      end else if (wr_beat) begin
         unique case (reg_sel)
            REG_ROWS: rows_ff <= pwdata[CSR_W-1:0];
            REG_COLS: cols_ff <= pwdata[CSR_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (reg_sel)
         REG_ROWS: prdata = PDATA_W'(rows_ff);
         REG_COLS: prdata = PDATA_W'(cols_ff);
         default:  prdata = '0;
      endcase
   end

   smet_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   smet_datapath #(
      .CAPACITY (CAPACITY),
      .MAX_DIM  (MAX_DIM)
   ) u_datapath (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .stat            (stat),
      .rows_in_use     (rows_ff),
      .cols_in_use     (cols_ff),
      .req_func        (req_func),
      .req_row         (req_row),
      .req_col         (req_col),
      .req_value       (req_value),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_status      (rsp_status),
      .rsp_row_total   (rsp_row_total),
      .rsp_entry_count (rsp_entry_count)
   );

endmodule
